### hdl/page_ecc32_xor32_checksum_core_defines.svh
// Assertion macros for the checksum core top level.
`ifndef PAGE_ECC32_XOR32_CHECKSUM_CORE_DEFINES_SVH
`define PAGE_ECC32_XOR32_CHECKSUM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PE32_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PE32_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pe32_pkg.sv
// Package with the constants, types and functions of the page checksum core.
package pe32_pkg;

    localparam logic [31:0] MASK_START = 32'hff80_0000;
    localparam logic [31:0] MASK_STEP  = 32'h007f_ff80;
    localparam logic [31:0] BIT_LANE01 = 32'h0040_0000;
    localparam logic [31:0] BIT_LANE02 = 32'h0020_0000;
    localparam logic [31:0] BIT_LANE13 = 32'h0000_0020;
    localparam logic [31:0] BIT_LANE23 = 32'h0000_0040;
    localparam logic [31:0] POS_START  = 32'hffff_0000;
    localparam logic [31:0] POS_STEP   = 32'h0000_ffff;
    localparam logic [31:0] LOW_MERGE  = 32'h001f_001f;
    localparam logic [15:0] SMALL_PAGE = 16'd8192;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAGE_SIZE   = 2'd0;
    localparam logic [1:0] CFG_START_LANE  = 2'd1;
    localparam logic [1:0] CFG_INITIAL_XOR = 2'd2;

    // Snapshot of a finished page, handed to the finishing stage
    typedef struct packed {
        logic [31:0]      ecc;
        logic [3:0][31:0] lane;
    } pe32_fin_t;

    // Bit-position mask: each set bit of the total XOR adds its position pattern
    function automatic logic [31:0] pos_mask(input logic [31:0] total);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (total[i])
            begin
                acc = acc ^ 32'(POS_START - 32'(i) * POS_STEP);
            end
        end
        return acc;
    endfunction

endpackage

### hdl/pe32_finish.sv
// Finishing logic: cross-lane parity, position mask, size mask and low-bit merge.
module pe32_finish (
    input  pe32_pkg::pe32_fin_t fin,
    input  logic [15:0]         page_size,
    input  logic [31:0]         initial_xor,
    output logic [31:0]         ecc_checksum,
    output logic [31:0]         xor_checksum
);
    import pe32_pkg::*;

    logic [31:0] total;
    logic [31:0] fmask;
    logic [31:0] ecc_cross;
    logic [31:0] ecc_sized;

    // Fold the lanes into the total word XOR
    assign total = fin.lane[0] ^ fin.lane[1] ^ fin.lane[2] ^ fin.lane[3];
    assign fmask = pos_mask(total);

    // Add the cross-lane parity bits
    always_comb
    begin
        ecc_cross = fin.ecc;
        if (^(fin.lane[0] ^ fin.lane[1]))
        begin
            ecc_cross = ecc_cross ^ BIT_LANE01;
        end
        if (^(fin.lane[0] ^ fin.lane[2]))
        begin
            ecc_cross = ecc_cross ^ BIT_LANE02;
        end
        if (^(fin.lane[1] ^ fin.lane[3]))
        begin
            ecc_cross = ecc_cross ^ BIT_LANE13;
        end
        if (^(fin.lane[2] ^ fin.lane[3]))
        begin
            ecc_cross = ecc_cross ^ BIT_LANE23;
        end
    end

    // Clear the size bits for small pages, then merge the low position bits
    always_comb
    begin
        ecc_sized = ecc_cross;
        if (page_size < SMALL_PAGE)
        begin
            ecc_sized = ecc_cross & ~{page_size[12:0], 19'd0};
        end
    end

    assign ecc_checksum = (ecc_sized & ~LOW_MERGE) | (fmask & LOW_MERGE);
    assign xor_checksum = initial_xor ^ total;

endmodule

### hdl/page_ecc32_xor32_checksum_core.sv
// Top level of the ECC-32 / XOR-32 page checksum core.
// Throughput: one page word per cycle while s_axis_tready is high, with no gaps between pages.
// Result path: the snapshot of the last word is loaded into the finish register, then
// the finishing logic feeds the output register on m_axis; both stall on m_axis_tready.
// Reset: rst_n clears all page state and loads page_size 4096, start_lane 2,
// initial_xor 0; the core is ready for words as soon as reset is released.
`include "page_ecc32_xor32_checksum_core_defines.svh"

module page_ecc32_xor32_checksum_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_word
    input  logic        s_axis_tlast,   // last_word
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [31:0] ecc_checksum, [63:32] xor_checksum
);
    import pe32_pkg::*;

    logic [15:0]      page_size_reg;
    logic [1:0]       start_lane_reg;
    logic [31:0]      initial_xor_reg;

    logic [31:0]      ecc_accum_reg, ecc_accum_next;
    logic [31:0]      group_mask_reg, group_mask_next;
    logic             group_parity_reg, group_parity_next;
    logic [3:0][31:0] lane_xor_reg, lane_xor_next;
    logic [1:0]       lane_pos_reg, lane_pos_next;

    logic             fin_valid_reg;
    pe32_fin_t        fin_reg, fin_next;
    logic             out_valid_reg;
    logic [63:0]      out_data_reg;

    logic             in_accept;
    logic             out_free;
    logic             fin_advance;
    logic [31:0]      ecc_checksum;
    logic [31:0]      xor_checksum;

    // Handshake: the output register and the finish register decouple the sides
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fin_advance   = fin_valid_reg && out_free;
    assign s_axis_tready = !fin_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Accumulate one word into the lane and group state
    always_comb
    begin
        logic gp;
        gp                = group_parity_reg ^ (^s_axis_tdata);
        lane_xor_next     = lane_xor_reg;
        lane_xor_next[lane_pos_reg] = lane_xor_reg[lane_pos_reg] ^ s_axis_tdata;
        ecc_accum_next    = ecc_accum_reg;
        group_mask_next   = group_mask_reg;
        group_parity_next = gp;
        lane_pos_next     = lane_pos_reg + 2'd1;
        if (lane_pos_reg == 2'd3)
        begin
            if (gp)
            begin
                ecc_accum_next = ecc_accum_reg ^ group_mask_reg;
            end
            group_mask_next   = group_mask_reg - MASK_STEP;
            group_parity_next = 1'b0;
            lane_pos_next     = 2'd0;
        end
        // close any partial group for the snapshot
        fin_next.ecc  = group_parity_next ? (ecc_accum_next ^ group_mask_next)
                                          : ecc_accum_next;
        fin_next.lane = lane_xor_next;
    end

    // Hold configuration and page state; clear the page after its last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg    <= 16'd4096;
            start_lane_reg   <= 2'd2;
            initial_xor_reg  <= '0;
            ecc_accum_reg    <= '0;
            group_mask_reg   <= MASK_START;
            group_parity_reg <= 1'b0;
            lane_xor_reg     <= '0;
            lane_pos_reg     <= 2'd2;
        end
        else
        begin
            if (in_accept)
            begin
                if (s_axis_tlast)
                begin
                    ecc_accum_reg    <= '0;
                    group_mask_reg   <= MASK_START;
                    group_parity_reg <= 1'b0;
                    lane_xor_reg     <= '0;
                    lane_pos_reg     <= start_lane_reg;
                end
                else
                begin
                    ecc_accum_reg    <= ecc_accum_next;
                    group_mask_reg   <= group_mask_next;
                    group_parity_reg <= group_parity_next;
                    lane_xor_reg     <= lane_xor_next;
                    lane_pos_reg     <= lane_pos_next;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PAGE_SIZE:   page_size_reg <= cfg_wdata[15:0];
                    CFG_START_LANE:
                    begin
                        start_lane_reg <= cfg_wdata[1:0];
                        lane_pos_reg   <= cfg_wdata[1:0];
                    end
                    CFG_INITIAL_XOR: initial_xor_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // Advance the finish and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept && s_axis_tlast)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_advance)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept && s_axis_tlast)
        begin
            fin_reg <= fin_next;
        end
        if (fin_advance)
        begin
            out_data_reg <= {xor_checksum, ecc_checksum};
        end
    end

    pe32_finish u_finish (
        .fin          (fin_reg),
        .page_size    (page_size_reg),
        .initial_xor  (initial_xor_reg),
        .ecc_checksum (ecc_checksum),
        .xor_checksum (xor_checksum)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A last word always leaves a pending snapshot
    `PE32_ASSERT_NEXT(a_last_loads_fin, in_accept && s_axis_tlast, fin_valid_reg,
        "last word did not load the finish stage")
    // A stalled snapshot holds
    `PE32_ASSERT_NEXT(a_fin_holds, fin_valid_reg && !fin_advance,
        fin_valid_reg && $stable(fin_reg), "finish stage lost its snapshot")
    // The page state is cleared after the last word
    `PE32_ASSERT_NEXT(a_page_cleared, in_accept && s_axis_tlast,
        ecc_accum_reg == '0 && group_mask_reg == MASK_START && lane_pos_reg == start_lane_reg,
        "page state not cleared after last word")
    // No word is taken while both result stages are full and stalled
    `PE32_ASSERT_NOW(a_no_overrun, fin_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready, "word accepted while result stages were full")

endmodule
